>>> rtl/sorted_key_table_top_assert.svh
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define SKT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, request/response types and cell control shared by the table RTL.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_BYTES = 8;

  localparam int KeyW = 64;
  localparam int PosW = 6;                 // position / result_position field
  localparam int CntFieldW = 7;            // entry_count field
  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  // Only the top KEY_BYTES bytes of a key take part.
  localparam logic [KeyW-1:0] KEY_MASK = ~({KeyW{1'b1}} >> (8 * KEY_BYTES));

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdSearch = 2'd1,
    CmdDelPos = 2'd2,
    CmdDelVal = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2,
    StRange    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e            command;
    logic [KeyW-1:0] key;
    logic [PosW-1:0] position;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [PosW-1:0]      result_position;
    logic [CntFieldW-1:0] entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    OpHold = 2'd0,
    OpCmp  = 2'd1,
    OpUp   = 2'd2,
    OpDown = 2'd3
  } cell_op_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e        op;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

  // Binary search unit status.
  typedef struct packed {
    logic            done;
    logic            found;
    logic [IdxW-1:0] where;
  } srch_rsp_t;

endpackage

>>> rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// Sorted key table cell
// One key slot: compares against the broadcast key, shifts up or down.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [skt_pkg::IdxW-1:0] cell_idx_i,
  input  skt_pkg::cell_ctrl_t     ctrl_i,
  input  logic [skt_pkg::KeyW-1:0] left_key_i,
  input  logic [skt_pkg::KeyW-1:0] right_key_i,
  output logic [skt_pkg::KeyW-1:0] key_o,
  output logic                    lt_o,
  output logic                    eq_o
);
  import skt_pkg::*;

  logic [KeyW-1:0] key_q;
  logic            lt_q, eq_q;

  // Key slot: up = make room above the insert point, down = close a gap.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OpUp: begin
        if (cell_idx_i > ctrl_i.idx) begin
          key_q <= left_key_i;
        end else if (cell_idx_i == ctrl_i.idx) begin
          key_q <= ctrl_i.key;
        end
      end
      OpDown: begin
        if (cell_idx_i >= ctrl_i.idx) begin
          key_q <= right_key_i;
        end
      end
      default: begin
        key_q <= key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.op == OpCmp) begin
      lt_q <= key_q < ctrl_i.key;
      eq_q <= key_q == ctrl_i.key;
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

>>> rtl/skt_search.sv
// ----------------------------------------------------------------------------
// Sorted key table binary search
// Walks lo/hi over the registered per-cell compare flags, one probe a cycle.
// ----------------------------------------------------------------------------
module skt_search (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [skt_pkg::CntW-1:0] count_i,
  input  logic [skt_pkg::DEPTH-1:0] lt_i,
  input  logic [skt_pkg::DEPTH-1:0] eq_i,
  output skt_pkg::srch_rsp_t       rsp_o
);
  import skt_pkg::*;

  // hi is kept as hi+1 so the range stays unsigned: empty when lo >= hp.
  logic [CntW-1:0] lo_q, lo_d, hp_q, hp_d;
  logic            busy_q, busy_d;
  srch_rsp_t       rsp_q, rsp_d;
  logic [CntW:0]   mid_sum;
  logic [IdxW-1:0] mid;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hp_q} - (CntW + 1)'(1);
  assign mid     = mid_sum[IdxW:1];

  always_comb begin
    lo_d   = lo_q;
    hp_d   = hp_q;
    busy_d = busy_q;
    rsp_d  = rsp_q;
    if (start_i) begin
      lo_d        = '0;
      hp_d        = count_i;
      busy_d      = 1'b1;
      rsp_d.done  = 1'b0;
      rsp_d.found = 1'b0;
      rsp_d.where = '0;
    end else if (busy_q) begin
      if (lo_q >= hp_q) begin
        busy_d     = 1'b0;
        rsp_d.done = 1'b1;
      end else if (lt_i[mid]) begin
        lo_d = CntW'(mid) + CntW'(1);
      end else if (eq_i[mid]) begin
        busy_d      = 1'b0;
        rsp_d.done  = 1'b1;
        rsp_d.found = 1'b1;
        rsp_d.where = mid;
      end else begin
        hp_d = CntW'(mid);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rsp_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rsp_q  <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hp_q <= hp_d;
  end

  assign rsp_o = rsp_q;

endmodule

>>> rtl/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// Sorted key table
// Ordered table of up to DEPTH keys with insert, search and two deletes.
// ----------------------------------------------------------------------------
// The table keeps its keys in ascending unsigned order in a chain of DEPTH
// cells, each holding one key; only the top KEY_BYTES bytes of a request key
// are kept. Every request returns exactly one response with a status, a
// position and the entry count after the command. For insert and delete at
// position, on the accept edge every cell compares its key with the request
// key; then, in the decide state once the output register is free, the
// chain shifts up or down as one unless the command fails. Search and delete
// by value add a binary search over the registered compare flags, one probe
// per cycle, before the response is loaded. One request is worked on at a
// time; a new request is taken as soon as the previous one has been placed
// in the output register, even if that response has not yet been taken.
// Stored keys need no clearing after reset: only the first entry_count
// cells are ever looked at.
module sorted_key_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  skt_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skt_pkg::rsp_t out_rsp_o
);
  import skt_pkg::*;

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SDecide = 2'd1;   // compare flags valid, act on them
  localparam logic [1:0] SSearch = 2'd2;   // binary search in flight

  logic [1:0]      state_q, state_d;
  req_t            req_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  rsp_t            out_q, rsp_d;
  logic            rsp_load;
  logic            slot_free;
  logic            srch_start;
  srch_rsp_t       srch;
  cell_ctrl_t      ctrl;

  logic [KeyW-1:0]  cell_key   [DEPTH];
  logic [KeyW-1:0]  left_key   [DEPTH];
  logic [KeyW-1:0]  right_key  [DEPTH];
  logic [DEPTH-1:0] lt_vec, eq_vec;
  logic [DEPTH-1:0] gt_vec;                // key above request, or slot unused
  logic [DEPTH-1:0] bnd_vec;               // first such slot: insert point
  logic [IdxW-1:0]  ins_where;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_key[i] = '0;
    end else begin : g_mid_l
      assign left_key[i] = cell_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_key[i] = '0;
    end else begin : g_mid_r
      assign right_key[i] = cell_key[i+1];
    end

    skt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IdxW'(i)),
      .ctrl_i      (ctrl),
      .left_key_i  (left_key[i]),
      .right_key_i (right_key[i]),
      .key_o       (cell_key[i]),
      .lt_o        (lt_vec[i]),
      .eq_o        (eq_vec[i])
    );
  end

  // --------------------------------------------------------------------------
  // Insert point: keys are sorted, so gt_vec is a run of zeros then ones.
  // The 0->1 edge is one-hot; encode it by OR-ing the indices.
  // --------------------------------------------------------------------------
  always_comb begin
    ins_where = '0;
    for (int i = 0; i < DEPTH; i++) begin
      gt_vec[i] = (CntW'(i) >= count_q) || !(lt_vec[i] || eq_vec[i]);
    end
    for (int i = 0; i < DEPTH; i++) begin
      bnd_vec[i] = gt_vec[i] && ((i == 0) || !gt_vec[(i == 0) ? 0 : i - 1]);
      if (bnd_vec[i]) begin
        ins_where |= IdxW'(i);
      end
    end
  end

  skt_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .count_i (count_q),
    .lt_i    (lt_vec),
    .eq_i    (eq_vec),
    .rsp_o   (srch)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == SIdle);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ctrl.op    = OpHold;
    ctrl.idx   = '0;
    ctrl.key   = req_q.key;
    srch_start = 1'b0;
    rsp_load   = 1'b0;
    rsp_d      = '0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          ctrl.op  = OpCmp;
          ctrl.key = in_req_i.key & KEY_MASK;
          state_d  = SDecide;
        end
      end
      SDecide: begin
        unique case (req_q.command) inside
          CmdInsert: begin
            if (slot_free) begin
              rsp_load = 1'b1;
              state_d  = SIdle;
              if (int'(count_q) >= DEPTH) begin
                rsp_d.status = StFull;
              end else begin
                ctrl.op               = OpUp;
                ctrl.idx              = ins_where;
                count_d               = count_q + CntW'(1);
                rsp_d.status          = StOk;
                rsp_d.result_position = PosW'(ins_where);
              end
            end
          end
          CmdDelPos: begin
            if (slot_free) begin
              rsp_load = 1'b1;
              state_d  = SIdle;
              if (int'(req_q.position) >= int'(count_q)) begin
                rsp_d.status = StRange;
              end else begin
                ctrl.op               = OpDown;
                ctrl.idx              = IdxW'(req_q.position);
                count_d               = count_q - CntW'(1);
                rsp_d.status          = StOk;
                rsp_d.result_position = req_q.position;
              end
            end
          end
          CmdSearch, CmdDelVal: begin
            srch_start = 1'b1;
            state_d    = SSearch;
          end
          default: begin
            state_d = SIdle;
          end
        endcase
      end
      SSearch: begin
        if (srch.done && slot_free) begin
          rsp_load = 1'b1;
          state_d  = SIdle;
          if (srch.found) begin
            rsp_d.status          = StOk;
            rsp_d.result_position = PosW'(srch.where);
            if (req_q.command == CmdDelVal) begin
              ctrl.op  = OpDown;
              ctrl.idx = srch.where;
              count_d  = count_q - CntW'(1);
            end
          end else begin
            rsp_d.status = StNotFound;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    rsp_d.entry_count = CntFieldW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= '{command:  in_req_i.command,
                 key:      in_req_i.key & KEY_MASK,
                 position: in_req_i.position};
    end
    if (rsp_load) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

>>> rtl/skt_checker.sv
// ----------------------------------------------------------------------------
// Sorted key table checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_key_table_top_assert.svh"

module skt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input skt_pkg::rsp_t out_rsp_o
);
  import skt_pkg::*;

  // A stalled response stays put.
  `SKT_ASSERT_NEXT(a_rsp_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o), "response changed while stalled")

  // Any failed command reports position zero.
  `SKT_ASSERT_IMPL(a_fail_pos, out_valid_o && (out_rsp_o.status != StOk), out_rsp_o.result_position == '0, "failed command with nonzero position")

  // Count never exceeds the table size.
  `SKT_ASSERT_IMPL(a_cnt_max, out_valid_o, out_rsp_o.entry_count <= CntFieldW'(DEPTH), "entry count above table size")

  // Table full only when every slot is taken.
  `SKT_ASSERT_IMPL(a_full_cnt, out_valid_o && (out_rsp_o.status == StFull), out_rsp_o.entry_count == CntFieldW'(DEPTH), "table full reported with free slots")

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
